// ===== sv/btpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared widths, calibration register indices and compensation constants
// for the barometric temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

   localparam int RawWidth  = 24;
   localparam int CalWidth  = 16;
   localparam int TempWidth = 19;
   localparam int PresWidth = 32;
   localparam int CsrIdxWidth = 3;

   // calibration register indices
   localparam logic [CsrIdxWidth-1:0] CsrCalSens     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrCalOff      = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrCalTcs      = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrCalTco      = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrCalTref     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrCalTempsens = 3'd5;

   // compensation constants
   localparam logic signed [19:0] TempBase     = 20'sd2000;
   localparam logic signed [19:0] VeryLowShift = 20'sd1500;

   // pipeline depth from accepted word to result strobe
   localparam int NumStages = 7;

endpackage

// ===== sv/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Second-order temperature compensation of raw barometric conversions.
// ----------------------------------------------------------------------------
// Usage:
//   Calibration: six 16-bit factory words are written through csr_we,
//   csr_index and csr_wdata, one per clock, while no word is in flight.
//   Indices above five are ignored; only the low 16 bits are kept.
//   Input: a raw pressure and raw temperature pair is taken on any clock
//   edge with start high; busy is never raised, so one word per cycle.
//   Output: the compensated temperature (0.01 degC) and pressure appear on
//   rsp_temp_centideg and rsp_pressure_comp for one cycle with rsp_valid.
//   A word passes through seven register stages on its way to the strobe:
//   temperature difference, calibration products, first-order terms and
//   squares, second-order correction, split pressure products, product
//   merge, and final scaling into the output register.
//   Throughput is one word per clock. The receiver cannot hold results
//   off, so there is no stall path.
//   Reset (synchronous, active high) clears the calibration words to zero
//   and drops every word in flight.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [btpc_pkg::RawWidth-1:0]           req_raw_pressure,
   input  logic [btpc_pkg::RawWidth-1:0]           req_raw_temperature,
   output logic                                    rsp_valid,
   output logic signed [btpc_pkg::TempWidth-1:0]   rsp_temp_centideg,
   output logic signed [btpc_pkg::PresWidth-1:0]   rsp_pressure_comp,
   input  logic                                    csr_we,
   input  logic [btpc_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [btpc_pkg::CalWidth-1:0]           csr_wdata
);
   import btpc_pkg::*;

   // calibration words
   logic [CalWidth-1:0] cal_sens_ff, cal_off_ff, cal_tcs_ff, cal_tco_ff;
   logic [CalWidth-1:0] cal_tref_ff, cal_tempsens_ff;

   logic [NumStages-1:0] vld_ff, vld_in;

   // stage 1
   logic signed [24:0]     s1_dt_ff, s1_dt_in;
   logic [RawWidth-1:0]    s1_d1_ff;
   // stage 2
   logic signed [41:0]     s2_pt_ff, s2_pt_in, s2_po_ff, s2_po_in, s2_ps_ff, s2_ps_in;
   logic signed [49:0]     s2_pdd_ff, s2_pdd_in;
   logic [RawWidth-1:0]    s2_d1_ff;
   // stage 3
   logic signed [18:0]     s3_a;
   logic signed [19:0]     s3_b;
   logic signed [37:0]     s3_sqa_full;
   logic signed [39:0]     s3_sqb_full;
   logic signed [19:0]     s3_temp_ff, s3_temp_in;
   logic [33:0]            s3_sqa_ff, s3_sqb_ff;
   logic                   s3_low_ff, s3_vlow_ff;
   logic signed [35:0]     s3_off_ff, s3_off_in;
   logic signed [34:0]     s3_sens_ff, s3_sens_in;
   logic [18:0]            s3_t2_ff;
   logic [RawWidth-1:0]    s3_d1_ff;
   // stage 4
   logic [36:0]            s4_sqa5;
   logic [36:0]            s4_sqb7;
   logic [37:0]            s4_sqb11;
   logic [37:0]            s4_off2, s4_sens2;
   logic signed [39:0]     s4_offc_ff, s4_offc_in, s4_sensc_ff, s4_sensc_in;
   logic signed [19:0]     s4_temp_ff, s4_temp_in;
   logic [RawWidth-1:0]    s4_d1_ff;
   // stage 5
   logic [43:0]            s5_lo_ff, s5_lo_in;
   logic signed [44:0]     s5_hi_ff, s5_hi_in;
   logic signed [39:0]     s5_offc_ff;
   logic signed [19:0]     s5_temp_ff;
   // stage 6
   logic signed [64:0]     s6_prod_ff, s6_prod_in;
   logic signed [39:0]     s6_offc_ff;
   logic signed [19:0]     s6_temp_ff;
   // stage 7
   logic signed [44:0]     s7_r;
   logic signed [PresWidth-1:0] rsp_pres_ff, rsp_pres_in;
   logic signed [TempWidth-1:0] rsp_temp_ff;

   assign busy = 1'b0;

   // calibration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_sens_ff     <= '0;
         cal_off_ff      <= '0;
         cal_tcs_ff      <= '0;
         cal_tco_ff      <= '0;
         cal_tref_ff     <= '0;
         cal_tempsens_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrCalSens:     cal_sens_ff     <= csr_wdata;
            CsrCalOff:      cal_off_ff      <= csr_wdata;
            CsrCalTcs:      cal_tcs_ff      <= csr_wdata;
            CsrCalTco:      cal_tco_ff      <= csr_wdata;
            CsrCalTref:     cal_tref_ff     <= csr_wdata;
            CsrCalTempsens: cal_tempsens_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign vld_in = {vld_ff[NumStages-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: temperature difference against the reference
   assign s1_dt_in = $signed({1'b0, req_raw_temperature})
                   - $signed({1'b0, cal_tref_ff, 8'b0});

   // stage 2: calibration products and the square of dT
   assign s2_pt_in  = $signed({1'b0, cal_tempsens_ff}) * s1_dt_ff;
   assign s2_po_in  = $signed({1'b0, cal_tco_ff}) * s1_dt_ff;
   assign s2_ps_in  = $signed({1'b0, cal_tcs_ff}) * s1_dt_ff;
   assign s2_pdd_in = s1_dt_ff * s1_dt_ff;

   // stage 3: first-order temperature, offset, sensitivity and squares
   assign s3_a        = s2_pt_ff[41:23];
   assign s3_temp_in  = TempBase + {s3_a[18], s3_a};
   assign s3_b        = {s3_a[18], s3_a} + (VeryLowShift + TempBase);
   assign s3_sqa_full = s3_a * s3_a;
   assign s3_sqb_full = s3_b * s3_b;
   assign s3_off_in   = $signed({4'b0, cal_off_ff, 16'b0}) + {s2_po_ff[41], s2_po_ff[41:7]};
   assign s3_sens_in  = $signed({4'b0, cal_sens_ff, 15'b0}) + {s2_ps_ff[41], s2_ps_ff[41:8]};

   // stage 4: second-order corrections, squares stay below 2^34
   assign s4_sqa5  = {1'b0, s3_sqa_ff, 2'b0} + {3'b0, s3_sqa_ff};
   assign s4_sqb7  = {s3_sqb_ff, 3'b0} - {3'b0, s3_sqb_ff};
   assign s4_sqb11 = {1'b0, s3_sqb_ff, 3'b0} + {3'b0, s3_sqb_ff, 1'b0}
                   + {4'b0, s3_sqb_ff};

   always_comb begin
      s4_off2  = '0;
      s4_sens2 = '0;
      if (s3_low_ff) begin
         s4_off2  = {2'b0, s4_sqa5[36:1]};
         s4_sens2 = {3'b0, s4_sqa5[36:2]};
         if (s3_vlow_ff) begin
            s4_off2  = s4_off2 + {1'b0, s4_sqb7};
            s4_sens2 = s4_sens2 + {1'b0, s4_sqb11[37:1]};
         end
      end
   end

   assign s4_offc_in  = {{4{s3_off_ff[35]}}, s3_off_ff} - $signed({2'b0, s4_off2});
   assign s4_sensc_in = {{5{s3_sens_ff[34]}}, s3_sens_ff} - $signed({2'b0, s4_sens2});
   assign s4_temp_in  = s3_low_ff ? (s3_temp_ff - $signed({1'b0, s3_t2_ff})) : s3_temp_ff;

   // stage 5: raw pressure times sensitivity, split in two halves
   assign s5_lo_in = s4_d1_ff * s4_sensc_ff[19:0];
   assign s5_hi_in = $signed({1'b0, s4_d1_ff}) * $signed(s4_sensc_ff[39:20]);

   // stage 6: merge the halves
   assign s6_prod_in = {s5_hi_ff, 20'b0} + $signed({21'b0, s5_lo_ff});

   // stage 7: scale, remove offset, scale again; the result always lies
   // well inside signed 32 bits so the sign extension is the saturation
   assign s7_r = {s6_prod_ff[64], s6_prod_ff[64:21]} - {{5{s6_offc_ff[39]}}, s6_offc_ff};
   assign rsp_pres_in = {{2{s7_r[44]}}, s7_r[44:15]};

   always_ff @(posedge clock) begin
      s1_dt_ff    <= s1_dt_in;
      s1_d1_ff    <= req_raw_pressure;

      s2_pt_ff    <= s2_pt_in;
      s2_po_ff    <= s2_po_in;
      s2_ps_ff    <= s2_ps_in;
      s2_pdd_ff   <= s2_pdd_in;
      s2_d1_ff    <= s1_d1_ff;

      s3_temp_ff  <= s3_temp_in;
      s3_sqa_ff   <= s3_sqa_full[33:0];
      s3_sqb_ff   <= s3_sqb_full[33:0];
      s3_low_ff   <= s3_a[18];
      s3_vlow_ff  <= s3_b[19];
      s3_off_ff   <= s3_off_in;
      s3_sens_ff  <= s3_sens_in;
      s3_t2_ff    <= s2_pdd_ff[49:31];
      s3_d1_ff    <= s2_d1_ff;

      s4_offc_ff  <= s4_offc_in;
      s4_sensc_ff <= s4_sensc_in;
      s4_temp_ff  <= s4_temp_in;
      s4_d1_ff    <= s3_d1_ff;

      s5_lo_ff    <= s5_lo_in;
      s5_hi_ff    <= s5_hi_in;
      s5_offc_ff  <= s4_offc_ff;
      s5_temp_ff  <= s4_temp_ff;

      s6_prod_ff  <= s6_prod_in;
      s6_offc_ff  <= s5_offc_ff;
      s6_temp_ff  <= s5_temp_ff;

      rsp_pres_ff <= rsp_pres_in;
      rsp_temp_ff <= s6_temp_ff[TempWidth-1:0];
   end

   assign rsp_valid         = vld_ff[NumStages-1];
   assign rsp_temp_centideg = rsp_temp_ff;
   assign rsp_pressure_comp = rsp_pres_ff;

   // a result word only ever follows an accepted word by the full latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, NumStages))
      else $error("result strobe without a matching accepted word");

   // very low temperature is a subset of low temperature
   a_vlow_in_low : assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && s3_vlow_ff |-> s3_low_ff)
      else $error("very low temperature flagged without low temperature");

   // second-order corrections only ever lower offset and temperature
   a_off_down : assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s4_offc_ff <= $signed({{4{$past(s3_off_ff[35])}}, $past(s3_off_ff)})))
      else $error("offset correction raised the offset");

   a_temp_down : assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s4_temp_ff <= $past(s3_temp_ff)))
      else $error("temperature correction raised the temperature");

endmodule
